FILE: hw/rtl/lwfw_pkg.sv
// Shared constants and types for the leak window floor watchdog.
package lwfw_pkg;

  // Action codes carried by each result word.
  localparam logic [1:0] ACT_NONE      = 2'd0;
  localparam logic [1:0] ACT_RECONNECT = 2'd1;
  localparam logic [1:0] ACT_TEARDOWN  = 2'd2;
  localparam logic [1:0] ACT_WARN      = 2'd3;

  // Cause codes, meaningful only when the action is not none.
  localparam logic CAUSE_GROWTH = 1'b0;
  localparam logic CAUSE_NEAR   = 1'b1;

  // Growth threshold: limit / 4 clamped to [256, 1024].
  localparam int         THRESH_BITS  = 11;
  localparam logic [10:0] THRESH_LOW  = 11'd256;
  localparam logic [10:0] THRESH_HIGH = 11'd1024;
  localparam int         LIMIT_SHIFT  = 2;

  // Near-limit ratio 0.85 as an exact integer compare, 100 * count > 85 * limit.
  localparam int         RATIO_BITS = 7;
  localparam logic [6:0] RATIO_NUM  = 7'd85;
  localparam logic [6:0] RATIO_DEN  = 7'd100;

  // Configuration register indexes.
  localparam int         CFG_INDEX_BITS     = 3;
  localparam logic [2:0] CFG_BASELINE       = 3'd0;
  localparam logic [2:0] CFG_BASELINE_KNOWN = 3'd1;
  localparam logic [2:0] CFG_LIMIT          = 3'd2;
  localparam logic [2:0] CFG_LIMIT_KNOWN    = 3'd3;
  localparam logic [2:0] CFG_KILL_SWITCH    = 3'd4;
  localparam logic [2:0] CFG_AUTO_RECONNECT = 3'd5;

  // Decision handed from the judge to the output stage.
  typedef struct packed {
    logic [1:0] action;
    logic       cause;
  } verdict_t;

endpackage

FILE: hw/rtl/lwfw_if.sv
// Handshake channels of the watchdog: tick input, result output and register writes.
interface lwfw_in_if #(parameter int COUNT_BITS = 20);
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] open_count;
  logic                  count_valid;
  logic                  link_active;
  logic                  stop_requested;

  modport source (output valid, open_count, count_valid, link_active, stop_requested,
                  input ready);
  modport sink   (input valid, open_count, count_valid, link_active, stop_requested,
                  output ready);
endinterface

interface lwfw_out_if #(parameter int COUNT_BITS = 20);
  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  logic                  cause;
  logic [COUNT_BITS-1:0] window_floor;
  logic [10:0]           growth_threshold;

  modport source (output valid, action, cause, window_floor, growth_threshold,
                  input ready);
  modport sink   (input valid, action, cause, window_floor, growth_threshold,
                  output ready);
endinterface

interface lwfw_cfg_if #(parameter int COUNT_BITS = 20);
  logic                  valid;
  logic                  ready;
  logic [2:0]            index;
  logic [COUNT_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/lwfw_cell.sv
// One window cell: holds the minimum of its own sample and every newer one.
module lwfw_cell #(
  parameter int COUNT_BITS = 20
) (
  input  logic                  clk,
  input  logic                  push,
  input  logic [COUNT_BITS-1:0] count,
  input  logic [COUNT_BITS-1:0] right_min,
  output logic [COUNT_BITS-1:0] held_min
);

  logic [COUNT_BITS-1:0] held_min_next;

  // On a push the cell takes its newer neighbor's minimum, folded with the new count.
  always_comb begin
    held_min_next = (right_min < count) ? right_min : count;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held_min <= held_min_next;
    end
  end

endmodule

FILE: hw/rtl/lwfw_judge.sv
// Threshold derivation, growth and near-limit checks, and action selection.
module lwfw_judge #(
  parameter int COUNT_BITS = 20
) (
  input  logic                   used,
  input  logic                   full,
  input  logic [COUNT_BITS-1:0]  count,
  input  logic [COUNT_BITS-1:0]  floor_val,
  input  logic                   stop_requested,
  input  logic [COUNT_BITS-1:0]  baseline,
  input  logic                   baseline_known,
  input  logic [COUNT_BITS-1:0]  limit,
  input  logic                   limit_known,
  input  logic                   kill_switch_on,
  input  logic                   auto_reconnect_on,
  output lwfw_pkg::verdict_t     verdict,
  output logic [10:0]            threshold
);
  import lwfw_pkg::*;

  localparam int TW = COUNT_BITS + THRESH_BITS;
  localparam int PW = COUNT_BITS + RATIO_BITS;

  logic [TW-1:0] quarter;
  logic [TW-1:0] thr_wide;
  logic [TW-1:0] bound;
  logic [PW-1:0] count_scaled;
  logic [PW-1:0] limit_scaled;
  logic          growth;
  logic          near;
  logic          fire;

  // Clamped threshold; an unknown or zero limit falls to the low clamp.
  always_comb begin
    quarter = TW'(limit >> LIMIT_SHIFT);
    if (!limit_known || quarter < TW'(THRESH_LOW)) begin
      thr_wide = TW'(THRESH_LOW);
    end else if (quarter > TW'(THRESH_HIGH)) begin
      thr_wide = TW'(THRESH_HIGH);
    end else begin
      thr_wide = quarter;
    end
  end

  assign threshold = thr_wide[THRESH_BITS-1:0];

  // Growth check against the baseline, near-limit check by constant multiplies.
  always_comb begin
    bound        = TW'(baseline) + thr_wide;
    growth       = baseline_known && full && (TW'(floor_val) >= bound);
    count_scaled = PW'(count) * PW'(RATIO_DEN);
    limit_scaled = PW'(limit) * PW'(RATIO_NUM);
    near         = limit_known && (count_scaled > limit_scaled);
    fire         = used && (growth || near);
  end

  // Kill switch keeps the link; otherwise reconnect if auto reconnect is on and no stop is requested, else tear down.
  always_comb begin
    verdict.action = ACT_NONE;
    verdict.cause  = CAUSE_GROWTH;
    if (fire) begin
      verdict.cause = growth ? CAUSE_GROWTH : CAUSE_NEAR;
      if (kill_switch_on) begin
        verdict.action = ACT_WARN;
      end else if (!stop_requested && auto_reconnect_on) begin
        verdict.action = ACT_RECONNECT;
      end else begin
        verdict.action = ACT_TEARDOWN;
      end
    end
  end

endmodule

FILE: hw/rtl/leak_window_floor_watchdog.sv
// Top level: register file, row of window cells, judge and two-entry result buffer.
//
//   channel   | role            | moves
//   ----------+-----------------+-------------------------------------------------
//   samples   | tick in (sink)  | open_count, count_valid, link_active, stop_requested
//   verdicts  | result (source) | action, cause, window_floor, growth_threshold
//   cfg       | registers (sink)| index, data; always ready
//
// Every accepted word yields one registered result word; one word per cycle while input ready stays high.
// The floor is one compare deep: each cell keeps the minimum of its sample and all newer ones.
// Reset clears the fill count, the result buffer and the registers (auto reconnect to 1).
// A stalled result is held while one more word is taken into the skid entry; input ready
// then drops until the skid entry drains.
module leak_window_floor_watchdog #(
  parameter int WINDOW_DEPTH = 6,
  parameter int COUNT_BITS   = 20
) (
  input  logic        clk,
  input  logic        rst,
  lwfw_cfg_if.sink    cfg,
  lwfw_in_if.sink     samples,
  lwfw_out_if.source  verdicts
);
  import lwfw_pkg::*;

  localparam int CELLS     = WINDOW_DEPTH - 1;
  localparam int FILL_BITS = $clog2(WINDOW_DEPTH + 1);

  // Configuration registers.
  logic [COUNT_BITS-1:0] baseline;
  logic                  baseline_known;
  logic [COUNT_BITS-1:0] occupancy_limit;
  logic                  limit_known;
  logic                  kill_switch_on;
  logic                  auto_reconnect_on;

  // Window control.
  logic [FILL_BITS-1:0]  fill_count;
  logic                  in_fire;
  logic                  push;
  logic                  full_next;
  logic [COUNT_BITS-1:0] cell_min [CELLS];
  logic [COUNT_BITS-1:0] floor_val;

  // Judge results.
  verdict_t              verdict;
  logic [10:0]           threshold;

  // Result buffer.
  logic                  out_valid;
  logic                  out_fire;
  logic [1:0]            out_action;
  logic                  out_cause;
  logic [COUNT_BITS-1:0] out_floor;
  logic [10:0]           out_thr;
  logic                  skid_valid;
  logic [1:0]            skid_action;
  logic                  skid_cause;
  logic [COUNT_BITS-1:0] skid_floor;
  logic [10:0]           skid_thr;
  logic [1:0]            new_action;
  logic                  new_cause;
  logic [COUNT_BITS-1:0] new_floor;

  // Register writes; unknown indexes are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline          <= '0;
      baseline_known    <= 1'b0;
      occupancy_limit   <= '0;
      limit_known       <= 1'b0;
      kill_switch_on    <= 1'b0;
      auto_reconnect_on <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_BASELINE:       baseline          <= cfg.data;
        CFG_BASELINE_KNOWN: baseline_known    <= cfg.data[0];
        CFG_LIMIT:          occupancy_limit   <= cfg.data;
        CFG_LIMIT_KNOWN:    limit_known       <= cfg.data[0];
        CFG_KILL_SWITCH:    kill_switch_on    <= cfg.data[0];
        CFG_AUTO_RECONNECT: auto_reconnect_on <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // A tick enters the window only with an active link and a readable count.
  assign samples.ready = !skid_valid;
  assign in_fire       = samples.valid && samples.ready;
  assign push          = in_fire && samples.count_valid && samples.link_active;
  assign full_next     = fill_count >= FILL_BITS'(WINDOW_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (push && fill_count != FILL_BITS'(WINDOW_DEPTH)) begin
      fill_count <= fill_count + FILL_BITS'(1);
    end
  end

  // Row of cells, oldest suffix first; the newest cell sees an all-ones neighbor.
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    logic [COUNT_BITS-1:0] right_min;
    if (i == CELLS - 1) begin : g_edge
      assign right_min = '1;
    end else begin : g_link
      assign right_min = cell_min[i + 1];
    end
    lwfw_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
      .clk       (clk),
      .push      (push),
      .count     (samples.open_count),
      .right_min (right_min),
      .held_min  (cell_min[i])
    );
  end

  // Window minimum including the word being pushed now.
  assign floor_val = (cell_min[0] < samples.open_count) ? cell_min[0] : samples.open_count;

  lwfw_judge #(.COUNT_BITS(COUNT_BITS)) u_judge (
    .used              (push),
    .full              (full_next),
    .count             (samples.open_count),
    .floor_val         (floor_val),
    .stop_requested    (samples.stop_requested),
    .baseline          (baseline),
    .baseline_known    (baseline_known),
    .limit             (occupancy_limit),
    .limit_known       (limit_known),
    .kill_switch_on    (kill_switch_on),
    .auto_reconnect_on (auto_reconnect_on),
    .verdict           (verdict),
    .threshold         (threshold)
  );

  assign new_action = verdict.action;
  assign new_cause  = verdict.cause;
  assign new_floor  = (push && full_next) ? floor_val : '0;

  // Result buffer control: output entry plus one skid entry.
  assign out_fire = out_valid && verdicts.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result buffer payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (!out_valid || out_fire) begin
        out_action <= new_action;
        out_cause  <= new_cause;
        out_floor  <= new_floor;
        out_thr    <= threshold;
      end else begin
        skid_action <= new_action;
        skid_cause  <= new_cause;
        skid_floor  <= new_floor;
        skid_thr    <= threshold;
      end
    end else if (out_fire && skid_valid) begin
      out_action <= skid_action;
      out_cause  <= skid_cause;
      out_floor  <= skid_floor;
      out_thr    <= skid_thr;
    end
  end

  assign verdicts.valid            = out_valid;
  assign verdicts.action           = out_action;
  assign verdicts.cause            = out_cause;
  assign verdicts.window_floor     = out_floor;
  assign verdicts.growth_threshold = out_thr;

`ifndef SYNTHESIS
  // The skid entry is only ever filled behind a waiting result.
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid entry valid without output entry");

  // The fill count saturates at the window depth.
  assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_BITS'(WINDOW_DEPTH))
    else $error("fill count beyond window depth");

  // A growth verdict implies the floor cleared at least the threshold.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_action != ACT_NONE && out_cause == CAUSE_GROWTH
      |-> out_floor >= out_thr)
    else $error("growth verdict with floor below threshold");

  // No verdict carries a near-limit cause without an action.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_action == ACT_NONE |-> out_cause == CAUSE_GROWTH)
    else $error("cause set on a result with no action");
`endif

endmodule

FILE: tb/sv/tb_leak_window_floor_watchdog.sv
// Self-checking testbench for the leak window floor watchdog with its own verdict predictor.
`timescale 1ns / 100ps

module tb_leak_window_floor_watchdog;
  import lwfw_pkg::*;

  localparam int COUNT_BITS      = 20;
  localparam int WINDOW_DEPTH    = 6;
  localparam int NUM_PHASES      = 10;
  localparam int TICKS_PER_PHASE = 175;
  localparam int HOLD_PHASE      = 3;
  localparam int LONG_HOLD       = 80;
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_CYCLES    = 20;
  localparam int REPORT_LIMIT    = 10;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // One result word as the block presents it.
  typedef struct packed {
    logic [1:0]            action;
    logic                  cause;
    logic [COUNT_BITS-1:0] window_floor;
    logic [10:0]           growth_threshold;
  } verdict_word_t;

  // Directed script: tick rows (optionally with a typed-in result) and register writes.
  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;
  typedef struct {
    row_kind_t             kind;
    logic [2:0]            reg_index;
    logic [COUNT_BITS-1:0] value;
    logic                  count_valid;
    logic                  link_active;
    logic                  stop_requested;
    int                    reps;
    bit                    typed_in;
    verdict_word_t         want;
  } script_row_t;

  logic clk;
  logic rst;

  lwfw_cfg_if #(.COUNT_BITS(COUNT_BITS)) cfg_ch ();
  lwfw_in_if  #(.COUNT_BITS(COUNT_BITS)) samples_ch ();
  lwfw_out_if #(.COUNT_BITS(COUNT_BITS)) verdicts_ch ();

  leak_window_floor_watchdog #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .COUNT_BITS  (COUNT_BITS)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .samples (samples_ch),
    .verdicts(verdicts_ch)
  );

  // Predictor copy of the registers and the sample window.
  logic [COUNT_BITS-1:0] reg_baseline;
  logic                  reg_baseline_known;
  logic [COUNT_BITS-1:0] reg_limit;
  logic                  reg_limit_known;
  logic                  reg_kill_switch;
  logic                  reg_auto_reconnect;
  logic [COUNT_BITS-1:0] floor_window [WINDOW_DEPTH];
  int                    fill_level;

  verdict_word_t pending_verdicts [$];
  script_row_t   script_q [$];
  int            mismatches = 0;
  int            results_seen = 0;
  int unsigned   cycle_count = 0;
  bit            gaps_on = 1'b1;
  bit            hold_request = 1'b0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Growth threshold: limit / 4 clamped to the low and high marks, low mark if no usable limit.
  function automatic logic [10:0] growth_mark();
    logic [COUNT_BITS-1:0] t;
    t = COUNT_BITS'(THRESH_LOW);
    if (reg_limit_known && reg_limit != '0) t = reg_limit >> LIMIT_SHIFT;
    if (t < COUNT_BITS'(THRESH_LOW)) t = COUNT_BITS'(THRESH_LOW);
    if (t > COUNT_BITS'(THRESH_HIGH)) t = COUNT_BITS'(THRESH_HIGH);
    return t[10:0];
  endfunction

  // Advances the window with one tick, if it is usable, and returns the verdict the block should give.
  function automatic verdict_word_t judge_tick(input logic [COUNT_BITS-1:0] count,
                                               input logic cv, input logic la,
                                               input logic sr);
    verdict_word_t         w;
    logic [COUNT_BITS-1:0] lo;
    longint unsigned       floor_wide;
    longint unsigned       mark_wide;
    longint unsigned       used_scaled;
    longint unsigned       limit_scaled;
    bit                    fire;
    logic                  why;
    w.action           = ACT_NONE;
    w.cause            = CAUSE_GROWTH;
    w.window_floor     = '0;
    w.growth_threshold = growth_mark();
    if (!cv || !la) return w;

    for (int i = 0; i < WINDOW_DEPTH - 1; i++) floor_window[i] = floor_window[i + 1];
    floor_window[WINDOW_DEPTH - 1] = count;
    if (fill_level < WINDOW_DEPTH) fill_level++;

    if (fill_level >= WINDOW_DEPTH) begin
      lo = floor_window[0];
      for (int i = 1; i < WINDOW_DEPTH; i++)
        if (floor_window[i] < lo) lo = floor_window[i];
      w.window_floor = lo;
    end

    // Growth needs a full window; the sum is kept wide so a high baseline never wraps.
    floor_wide   = w.window_floor;
    mark_wide    = reg_baseline;
    mark_wide    = mark_wide + w.growth_threshold;
    used_scaled  = count;
    used_scaled  = used_scaled * RATIO_DEN;
    limit_scaled = reg_limit;
    limit_scaled = limit_scaled * RATIO_NUM;
    fire = 1'b0;
    why  = CAUSE_GROWTH;
    if (reg_baseline_known && fill_level >= WINDOW_DEPTH && floor_wide >= mark_wide) begin
      fire = 1'b1;
    end else if (reg_limit_known && used_scaled > limit_scaled) begin
      fire = 1'b1;
      why  = CAUSE_NEAR;
    end

    if (fire) begin
      w.cause = why;
      if (reg_kill_switch) w.action = ACT_WARN;
      else if (!sr && reg_auto_reconnect) w.action = ACT_RECONNECT;
      else w.action = ACT_TEARDOWN;
    end
    return w;
  endfunction

  function automatic verdict_word_t make_word(input logic [1:0] act, input logic why,
                                              input logic [COUNT_BITS-1:0] lo,
                                              input logic [10:0] thr);
    verdict_word_t w;
    w.action           = act;
    w.cause            = why;
    w.window_floor     = lo;
    w.growth_threshold = thr;
    return w;
  endfunction

  function automatic void add_tick(input logic [COUNT_BITS-1:0] count, input logic cv,
                                   input logic la, input logic sr, input int reps);
    script_row_t r;
    r.kind           = ROW_TICK;
    r.reg_index      = CFG_BASELINE;
    r.value          = count;
    r.count_valid    = cv;
    r.link_active    = la;
    r.stop_requested = sr;
    r.reps           = reps;
    r.typed_in       = 1'b0;
    r.want           = '0;
    script_q.push_back(r);
  endfunction

  function automatic void add_fixed(input logic [COUNT_BITS-1:0] count, input logic cv,
                                    input logic la, input logic sr, input int reps,
                                    input verdict_word_t want);
    add_tick(count, cv, la, sr, reps);
    script_q[script_q.size() - 1].typed_in = 1'b1;
    script_q[script_q.size() - 1].want     = want;
  endfunction

  function automatic void add_write(input logic [2:0] reg_index,
                                    input logic [COUNT_BITS-1:0] value);
    script_row_t r;
    r = '{kind: ROW_WRITE, reg_index: reg_index, value: value, count_valid: 1'b0,
          link_active: 1'b0, stop_requested: 1'b0, reps: 1, typed_in: 1'b0, want: '0};
    script_q.push_back(r);
  endfunction

  // Sender gaps: mostly none, some short, a few long.
  function automatic int draw_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 19);
    if (r < 13) return 0;
    if (r < 19) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Counts cluster around the growth mark and the near-limit edge, with some noise.
  function automatic logic [COUNT_BITS-1:0] draw_count();
    longint v;
    longint lim;
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, 32'(COUNT_MAX));
      1: v = ($urandom_range(0, 1) != 0) ? longint'(COUNT_MAX) : 0;
      2, 3: begin
        lim = reg_limit;
        v = lim * 85 / 100 + $urandom_range(0, 4) - 2;
      end
      default: begin
        v = reg_baseline;
        v = v + growth_mark() + $urandom_range(0, 600) - 300;
      end
    endcase
    if (v < 0) v = 0;
    if (v > longint'(COUNT_MAX)) v = COUNT_MAX;
    return v[COUNT_BITS-1:0];
  endfunction

  // Offers one tick word and records the expected verdict once it is taken.
  task automatic send_tick(input logic [COUNT_BITS-1:0] count, input logic cv,
                           input logic la, input logic sr, input bit typed_in,
                           input verdict_word_t want);
    verdict_word_t predicted;
    int            gap;
    samples_ch.valid          <= 1'b1;
    samples_ch.open_count     <= count;
    samples_ch.count_valid    <= cv;
    samples_ch.link_active    <= la;
    samples_ch.stop_requested <= sr;
    @(posedge clk);
    while (!samples_ch.ready) @(posedge clk);
    predicted = judge_tick(count, cv, la, sr);
    pending_verdicts.push_back(typed_in ? want : predicted);
    gap = draw_gap();
    if (gap > 0) begin
      samples_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the tick side quiet until every expected verdict has come back.
  task automatic wait_for_idle();
    samples_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] reg_index, input logic [COUNT_BITS-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= reg_index;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (reg_index)
      CFG_BASELINE:       reg_baseline       = value;
      CFG_BASELINE_KNOWN: reg_baseline_known = value[0];
      CFG_LIMIT:          reg_limit          = value;
      CFG_LIMIT_KNOWN:    reg_limit_known    = value[0];
      CFG_KILL_SWITCH:    reg_kill_switch    = value[0];
      CFG_AUTO_RECONNECT: reg_auto_reconnect = value[0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // New register settings for a random phase; the first two pin the extremes.
  task automatic pick_settings(input int phase);
    logic [COUNT_BITS-1:0] base;
    logic [COUNT_BITS-1:0] lim;
    logic [COUNT_BITS-1:0] flag_word;
    case ($urandom_range(0, 3))
      0: base = '0;
      1: base = COUNT_MAX;
      2: base = COUNT_BITS'($urandom_range(0, 4000));
      default: base = COUNT_BITS'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0: lim = '0;
      1: lim = COUNT_MAX;
      2: lim = COUNT_BITS'($urandom_range(0, 5000));
      3: lim = COUNT_BITS'($urandom_range(1000, 4096));
      default: lim = COUNT_BITS'($urandom);
    endcase
    if (phase == 0) begin
      base = '0;
      lim  = COUNT_MAX;
    end else if (phase == 1) begin
      base = COUNT_MAX;
      lim  = '0;
    end
    wait_for_idle();
    write_reg(CFG_BASELINE, base);
    write_reg(CFG_LIMIT, lim);
    // Flag registers keep only bit 0; the upper bits carry noise.
    flag_word = COUNT_BITS'($urandom);
    flag_word[0] = ($urandom_range(0, 3) != 0);
    write_reg(CFG_BASELINE_KNOWN, flag_word);
    flag_word = COUNT_BITS'($urandom);
    flag_word[0] = ($urandom_range(0, 2) != 0);
    write_reg(CFG_LIMIT_KNOWN, flag_word);
    flag_word = COUNT_BITS'($urandom);
    flag_word[0] = ($urandom_range(0, 3) == 0);
    write_reg(CFG_KILL_SWITCH, flag_word);
    flag_word = COUNT_BITS'($urandom);
    flag_word[0] = ($urandom_range(0, 3) != 0);
    write_reg(CFG_AUTO_RECONNECT, flag_word);
  endtask

  // Result side: random stalls, plus one long hold-off when the sender asks for it.
  initial begin : verdict_sink
    int stall_left;
    stall_left = 0;
    verdicts_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        verdicts_ch.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD - 1;
        verdicts_ch.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 2);
        verdicts_ch.ready <= 1'b0;
      end else begin
        verdicts_ch.ready <= 1'b1;
      end
    end
  end

  // Compares every accepted verdict word with the oldest expectation.
  always @(posedge clk) begin
    verdict_word_t got;
    verdict_word_t want;
    if (!rst && verdicts_ch.valid && verdicts_ch.ready) begin
      got.action           = verdicts_ch.action;
      got.cause            = verdicts_ch.cause;
      got.window_floor     = verdicts_ch.window_floor;
      got.growth_threshold = verdicts_ch.growth_threshold;
      if (pending_verdicts.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected verdict word: action %0d cause %0d floor %0d threshold %0d",
                   got.action, got.cause, got.window_floor, got.growth_threshold);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (got.action !== want.action || got.cause !== want.cause ||
            got.window_floor !== want.window_floor ||
            got.growth_threshold !== want.growth_threshold) begin
          if (mismatches < REPORT_LIMIT)
            $display("verdict %0d: expected action %0d cause %0d floor %0d threshold %0d, %s",
                     results_seen, want.action, want.cause, want.window_floor,
                     want.growth_threshold,
                     $sformatf("got action %0d cause %0d floor %0d threshold %0d",
                               got.action, got.cause, got.window_floor,
                               got.growth_threshold));
          mismatches++;
        end
      end
      results_seen++;
    end
  end

  // Main sequence: reset, directed script, random phases, drain.
  initial begin : stimulus
    logic [COUNT_BITS-1:0] count;
    logic                  cv;
    logic                  la;
    logic                  sr;
    rst                       <= 1'b1;
    samples_ch.valid          <= 1'b0;
    samples_ch.open_count     <= '0;
    samples_ch.count_valid    <= 1'b0;
    samples_ch.link_active    <= 1'b0;
    samples_ch.stop_requested <= 1'b0;
    cfg_ch.valid              <= 1'b0;
    cfg_ch.index              <= CFG_BASELINE;
    cfg_ch.data               <= '0;

    // Predictor state after reset.
    reg_baseline       = '0;
    reg_baseline_known = 1'b0;
    reg_limit          = '0;
    reg_limit_known    = 1'b0;
    reg_kill_switch    = 1'b0;
    reg_auto_reconnect = 1'b1;
    fill_level         = 0;
    foreach (floor_window[i]) floor_window[i] = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Ignored ticks and window fill with nothing known: no action, low threshold.
    add_fixed(COUNT_MAX, 1'b0, 1'b1, 1'b0, 1, make_word(ACT_NONE, CAUSE_GROWTH, '0, THRESH_LOW));
    add_fixed('0, 1'b1, 1'b0, 1'b1, 1, make_word(ACT_NONE, CAUSE_GROWTH, '0, THRESH_LOW));
    add_fixed('0, 1'b1, 1'b1, 1'b0, 1, make_word(ACT_NONE, CAUSE_GROWTH, '0, THRESH_LOW));
    add_fixed(COUNT_MAX, 1'b1, 1'b1, 1'b1, 4, make_word(ACT_NONE, CAUSE_GROWTH, '0, THRESH_LOW));
    add_fixed(COUNT_MAX, 1'b1, 1'b1, 1'b0, 1, make_word(ACT_NONE, CAUSE_GROWTH, '0, THRESH_LOW));
    add_fixed(COUNT_MAX, 1'b1, 1'b1, 0, 1,
              make_word(ACT_NONE, CAUSE_GROWTH, COUNT_MAX, THRESH_LOW));
    // Floor growth under each way of answering it.
    add_write(CFG_BASELINE, '0);
    add_write(CFG_BASELINE_KNOWN, 1);
    add_fixed(COUNT_MAX, 1'b1, 1'b1, 1'b0, 1,
              make_word(ACT_RECONNECT, CAUSE_GROWTH, COUNT_MAX, THRESH_LOW));
    add_fixed(COUNT_MAX, 1'b1, 1'b1, 1'b1, 1,
              make_word(ACT_TEARDOWN, CAUSE_GROWTH, COUNT_MAX, THRESH_LOW));
    add_write(CFG_KILL_SWITCH, 1);
    add_fixed(COUNT_MAX, 1'b1, 1'b1, 1'b0, 1,
              make_word(ACT_WARN, CAUSE_GROWTH, COUNT_MAX, THRESH_LOW));
    add_write(CFG_KILL_SWITCH, 0);
    add_write(CFG_AUTO_RECONNECT, 0);
    add_fixed(COUNT_MAX, 1'b1, 1'b1, 1'b0, 1,
              make_word(ACT_TEARDOWN, CAUSE_GROWTH, COUNT_MAX, THRESH_LOW));
    // Baseline at full scale: the growth mark lies past the count range and never fires.
    add_write(CFG_AUTO_RECONNECT, 1);
    add_write(CFG_BASELINE, COUNT_MAX);
    add_fixed(COUNT_MAX, 1'b1, 1'b1, 1'b0, 1,
              make_word(ACT_NONE, CAUSE_GROWTH, COUNT_MAX, THRESH_LOW));
    // Known zero limit: any nonzero count is near the limit.
    add_write(CFG_LIMIT, '0);
    add_write(CFG_LIMIT_KNOWN, 1);
    add_tick(1, 1'b1, 1'b1, 1'b0, 1);
    add_tick(0, 1'b1, 1'b1, 1'b0, 1);
    // Growth exactly at the mark, then one below it.
    add_write(CFG_BASELINE, 1000);
    add_write(CFG_LIMIT, 4096);
    add_tick(2024, 1'b1, 1'b1, 1'b0, 6);
    add_tick(2023, 1'b1, 1'b1, 1'b0, 1);
    // Near-limit edge: 85 percent is not over, one more is.
    add_write(CFG_BASELINE_KNOWN, 0);
    add_write(CFG_LIMIT, 100);
    add_tick(85, 1'b1, 1'b1, 1'b0, 1);
    add_tick(86, 1'b1, 1'b1, 1'b1, 1);
    // Unknown limit ignores its value; a full-scale known limit clamps the threshold high.
    add_write(CFG_LIMIT_KNOWN, 0);
    add_write(CFG_LIMIT, COUNT_MAX);
    add_tick(COUNT_MAX, 1'b1, 1'b1, 1'b0, 1);
    add_write(CFG_LIMIT_KNOWN, 1);
    add_tick(COUNT_MAX, 1'b1, 1'b1, 1'b0, 1);

    foreach (script_q[i]) begin
      if (script_q[i].kind == ROW_WRITE) begin
        wait_for_idle();
        write_reg(script_q[i].reg_index, script_q[i].value);
      end else begin
        repeat (script_q[i].reps)
          send_tick(script_q[i].value, script_q[i].count_valid, script_q[i].link_active,
                    script_q[i].stop_requested, script_q[i].typed_in, script_q[i].want);
      end
    end

    // Random phases; some run without gaps, one holds off the result side for a long stretch.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      gaps_on = !((phase % 3) == 2 || phase == HOLD_PHASE);
      pick_settings(phase);
      if (phase == HOLD_PHASE) hold_request = 1'b1;
      repeat (TICKS_PER_PHASE) begin
        count = draw_count();
        cv    = ($urandom_range(0, 11) != 0);
        la    = ($urandom_range(0, 11) != 0);
        sr    = ($urandom_range(0, 2) == 0);
        send_tick(count, cv, la, sr, 1'b0, '0);
      end
    end

    wait_for_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_verdicts.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
